// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/bba_pkg.sv
package bba_pkg;

    localparam int ROW_W      = 64;
    localparam int ROW_LOG    = 6;
    localparam int MAP_AW_MAX = 12;
    localparam int LVL_W      = 5;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_BADORDER = 3'd2,
        STAT_NULL     = 3'd3,
        STAT_OUTSIDE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_SET_RD,
        ST_SET_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  rd_en;
        logic [MAP_AW_MAX-1:0] rd_addr;
        logic                  wr_en;
        logic [MAP_AW_MAX-1:0] wr_addr;
        logic [ROW_W-1:0]      wr_data;
    } map_req_t;

    typedef struct packed {
        logic             inc;
        logic             dec;
        logic [LVL_W-1:0] level;
    } cnt_op_t;

    function automatic logic [ROW_LOG-1:0] ffs_row(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0]   v;
        logic [ROW_LOG-1:0] idx;
        int unsigned        half;
        v   = row;
        idx = '0;
        for (int s = ROW_LOG - 1; s >= 0; s--)
        begin
            half = 1 << s;
            if ((v & ((ROW_W'(1) << half) - ROW_W'(1))) == '0)
            begin
                idx = idx | ROW_LOG'(half);
                v   = v >> half;
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/bba_if.sv
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  block_order;
    logic [63:0] block_address;

    modport source (output valid, output action, output block_order, output block_address,
                    input ready);
    modport sink (input valid, input action, input block_order, input block_address,
                  output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] granted_address;
    logic [2:0]  status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink (input valid, input granted_address, input status, output ready);
endinterface

// File: hw/rtl/bba_map_ram.sv
module bba_map_ram #(
    parameter int ROWS = 37,
    parameter int AW   = 6
) (
    input  logic                      clk,
    input  bba_pkg::map_req_t         req,
    output logic [bba_pkg::ROW_W-1:0] rd_data
);
    import bba_pkg::*;

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr[AW-1:0]];
        end
    end

endmodule

// File: hw/rtl/bba_free_cnt.sv
module bba_free_cnt #(
    parameter int TOP_ORDER = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bba_pkg::cnt_op_t op,
    output logic [TOP_ORDER:0] nonzero
);
    import bba_pkg::*;

    localparam int K_W = $clog2(TOP_ORDER + 1);
    localparam int C_W = TOP_ORDER + 1;

    logic [C_W-1:0] cnt_reg  [TOP_ORDER + 1];
    logic [C_W-1:0] cnt_next [TOP_ORDER + 1];
    logic [K_W-1:0] idx;

    assign idx = op.level[K_W-1:0];

    always_comb
    begin
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (op.inc)
        begin
            cnt_next[idx] = cnt_reg[idx] + C_W'(1);
        end
        else if (op.dec)
        begin
            cnt_next[idx] = cnt_reg[idx] - C_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                cnt_reg[i] <= (i == TOP_ORDER) ? C_W'(1) : '0;
            end
        end
        else
        begin
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            nonzero[i] = (cnt_reg[i] != '0);
        end
    end

endmodule

// File: hw/rtl/buddy_block_allocator.sv
// Sequence from the transfer cycle, alloc: check, scan the rows at the chosen order, then split level
//   by level; free: check, merge with free buddies level by level, then set its bit; a reject only checks.
// Throughput: one item at a time, since req.ready is high only in idle; an order-0 alloc at TOP_ORDER 10
//   may scan all 16 order-0 rows.
// Reset: rst_n clears control asynchronously; a clearing pass then writes every map row,
//   37 rows at TOP_ORDER 10, before the first item is taken.
module buddy_block_allocator #(
    parameter int TOP_ORDER = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    bba_req_if.sink     req,
    bba_rsp_if.source   rsp
);
    import bba_pkg::*;

    localparam int ROWS = (TOP_ORDER <= 6) ? TOP_ORDER + 1 : 5 + (1 << TOP_ORDER) / 32;
    localparam int AW   = $clog2(ROWS);
    localparam int K_W  = $clog2(TOP_ORDER + 1);
    localparam int J_W  = TOP_ORDER;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_ptr_reg, clr_ptr_next;
    logic [63:0]      base_reg, base_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             action_reg, action_next;
    logic [5:0]       order_reg, order_next;
    logic [63:0]      addr_in_reg, addr_in_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [J_W-1:0]   j_reg, j_next;
    logic [AW-1:0]    row_ptr_reg, row_ptr_next;
    status_t          status_reg, status_next;
    logic [63:0]      rsp_addr_reg, rsp_addr_next;
    status_t          rsp_status_reg, rsp_status_next;

    map_req_t         mreq;
    logic [ROW_W-1:0] mrd;
    cnt_op_t          cop;
    logic [TOP_ORDER:0] nz;

    logic             found;
    logic [K_W-1:0]   kf;
    logic [63:0]      off;
    logic             outside;
    logic [J_W-1:0]   j_free;
    logic [J_W-1:0]   j_scan;
    logic [J_W-1:0]   buddy_j;
    logic [J_W-1:0]   split_j;
    logic [ROW_LOG-1:0] scan_bit;
    logic             above;
    logic             split_hit;
    logic             buddy_hit;
    logic             self_hit;
    logic             out_free;

    function automatic logic [AW-1:0] row_of(input logic [K_W-1:0] k, input logic [J_W-1:0] j);
        logic [7:0]  d;
        logic [31:0] jx;
        logic [31:0] r;
        d  = 8'(TOP_ORDER) - 8'(k);
        jx = 32'(j);
        if (d <= 8'd6)
        begin
            r = 32'(d);
        end
        else
        begin
            r = 32'd5 + (32'd1 << (d - 8'd6)) + (jx >> ROW_LOG);
        end
        return AW'(r);
    endfunction

    function automatic logic [ROW_LOG-1:0] bit_of(input logic [J_W-1:0] j);
        logic [31:0] jx;
        jx = 32'(j);
        return jx[ROW_LOG-1:0];
    endfunction

    bba_map_ram #(
        .ROWS (ROWS),
        .AW   (AW)
    ) u_map (
        .clk     (clk),
        .req     (mreq),
        .rd_data (mrd)
    );

    bba_free_cnt #(
        .TOP_ORDER (TOP_ORDER)
    ) u_cnt (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (cop),
        .nonzero (nz)
    );

    always_comb
    begin
        found = 1'b0;
        kf    = '0;
        for (int i = TOP_ORDER; i >= 0; i--)
        begin
            if (nz[i] && (i >= int'(order_reg)))
            begin
                found = 1'b1;
                kf    = K_W'(i);
            end
        end
    end

    assign off       = addr_in_reg - base_reg;
    assign outside   = (off >> TOP_ORDER) != 64'd0;
    assign j_free    = J_W'(off[TOP_ORDER-1:0] >> order_reg);
    assign scan_bit  = ffs_row(mrd);
    assign j_scan    = J_W'(((32'(row_ptr_reg) - 32'(row_of(k_reg, '0))) << ROW_LOG)
                            | 32'(scan_bit));
    assign buddy_j   = j_reg ^ J_W'(1);
    assign split_j   = j_reg | J_W'(1);
    assign above     = 6'(k_reg) > order_reg;
    assign split_hit = mrd[bit_of(split_j)];
    assign buddy_hit = mrd[bit_of(buddy_j)];
    assign self_hit  = mrd[bit_of(j_reg)];
    assign out_free  = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_ptr_reg == AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (order_reg > 6'(TOP_ORDER))
                begin
                    state_next = ST_DONE;
                end
                else if (action_reg == ACT_ALLOC)
                begin
                    state_next = found ? ST_SCAN_RD : ST_DONE;
                end
                else if ((addr_in_reg == 64'd0) || outside)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MERGE_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (mrd != '0)
                begin
                    state_next = above ? ST_SPLIT_RD : ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SPLIT_RD:
            begin
                state_next = ST_SPLIT_WR;
            end
            ST_SPLIT_WR:
            begin
                state_next = above ? ST_SPLIT_RD : ST_DONE;
            end
            ST_MERGE_RD:
            begin
                state_next = (k_reg == K_W'(TOP_ORDER)) ? ST_SET_RD : ST_MERGE_CHK;
            end
            ST_MERGE_CHK:
            begin
                state_next = buddy_hit ? ST_MERGE_RD : ST_SET_RD;
            end
            ST_SET_RD:
            begin
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mreq      = '0;
        cop       = '0;
        cop.level = LVL_W'(k_reg);
        req.ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = MAP_AW_MAX'(clr_ptr_reg);
                mreq.wr_data = (clr_ptr_reg == '0) ? ROW_W'(1) : '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = MAP_AW_MAX'(row_ptr_reg);
            end
            ST_SCAN_CHK:
            begin
                if (mrd != '0)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = MAP_AW_MAX'(row_ptr_reg);
                    mreq.wr_data = mrd & ~(ROW_W'(1) << scan_bit);
                    cop.dec      = 1'b1;
                end
            end
            ST_SPLIT_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = MAP_AW_MAX'(row_of(k_reg, split_j));
            end
            ST_SPLIT_WR:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = MAP_AW_MAX'(row_of(k_reg, split_j));
                mreq.wr_data = mrd | (ROW_W'(1) << bit_of(split_j));
                cop.inc      = !split_hit;
            end
            ST_MERGE_RD:
            begin
                if (k_reg != K_W'(TOP_ORDER))
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = MAP_AW_MAX'(row_of(k_reg, buddy_j));
                end
            end
            ST_MERGE_CHK:
            begin
                if (buddy_hit)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = MAP_AW_MAX'(row_of(k_reg, buddy_j));
                    mreq.wr_data = mrd & ~(ROW_W'(1) << bit_of(buddy_j));
                    cop.dec      = 1'b1;
                end
            end
            ST_SET_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = MAP_AW_MAX'(row_of(k_reg, j_reg));
            end
            ST_SET_WR:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = MAP_AW_MAX'(row_of(k_reg, j_reg));
                mreq.wr_data = mrd | (ROW_W'(1) << bit_of(j_reg));
                cop.inc      = !self_hit;
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    always_comb
    begin
        clr_ptr_next    = clr_ptr_reg;
        base_next       = base_reg;
        rsp_valid_next  = rsp_valid_reg;
        action_next     = action_reg;
        order_next      = order_reg;
        addr_in_next    = addr_in_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        row_ptr_next    = row_ptr_reg;
        status_next     = status_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;

        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
        end
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    action_next  = req.action;
                    order_next   = req.block_order;
                    addr_in_next = req.block_address;
                end
            end
            ST_CHECK:
            begin
                status_next = STAT_OK;
                k_next      = K_W'(order_reg);
                if (order_reg > 6'(TOP_ORDER))
                begin
                    status_next = STAT_BADORDER;
                end
                else if (action_reg == ACT_ALLOC)
                begin
                    if (found)
                    begin
                        k_next       = kf;
                        row_ptr_next = row_of(kf, '0);
                    end
                    else
                    begin
                        status_next = STAT_NOSPACE;
                    end
                end
                else if (addr_in_reg == 64'd0)
                begin
                    status_next = STAT_NULL;
                end
                else if (outside)
                begin
                    status_next = STAT_OUTSIDE;
                end
                else
                begin
                    j_next = j_free;
                end
            end
            ST_SCAN_CHK:
            begin
                if (mrd != '0)
                begin
                    if (above)
                    begin
                        k_next = k_reg - K_W'(1);
                        j_next = j_scan << 1;
                    end
                    else
                    begin
                        j_next = j_scan;
                    end
                end
                else
                begin
                    row_ptr_next = row_ptr_reg + AW'(1);
                end
            end
            ST_SPLIT_WR:
            begin
                if (above)
                begin
                    k_next = k_reg - K_W'(1);
                    j_next = j_reg << 1;
                end
            end
            ST_MERGE_CHK:
            begin
                if (buddy_hit)
                begin
                    k_next = k_reg + K_W'(1);
                    j_next = j_reg >> 1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    if ((status_reg == STAT_OK) && (action_reg == ACT_ALLOC))
                    begin
                        rsp_addr_next = base_reg + (64'(j_reg) << k_reg);
                    end
                    else
                    begin
                        rsp_addr_next = 64'd0;
                    end
                end
            end
            default:
            begin
                row_ptr_next = row_ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            base_reg      <= 64'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            base_reg      <= base_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        order_reg      <= order_next;
        addr_in_reg    <= addr_in_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        row_ptr_reg    <= row_ptr_next;
        status_reg     <= status_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted_address = rsp_addr_reg;
    assign rsp.status          = rsp_status_reg;

endmodule

// File: hw/rtl/bba_checker.sv
`include "assert_macros.svh"

module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_granted_address,
    input logic [2:0]  rsp_status
);
    import bba_pkg::*;

    // hold a stalled response
    `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_address))

    // drop ready after a request transfer
    `BBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    `BBA_ASSERT_NOW(a_status_legal, clk, rst_n, rsp_valid, rsp_status <= STAT_OUTSIDE)

    `BBA_ASSERT_NOW(a_fail_no_addr, clk, rst_n, rsp_valid && (rsp_status != STAT_OK), rsp_granted_address == 64'd0)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_granted_address (rsp.granted_address),
    .rsp_status          (rsp.status)
);
